### hw/rtl/gradient_noise_3d_macros.svh
// Assertion macros shared by the checker.
`ifndef GRADIENT_NOISE_3D_MACROS_SVH
`define GRADIENT_NOISE_3D_MACROS_SVH

// Assert that an implication holds on every clock edge outside reset.
`define GN_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Assert that an implication holds in the cycle after the antecedent.
`define GN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/gn3d_pkg.sv
`default_nettype none
package gn3d_pkg;

   localparam int unsigned FRAC_W  = 16;
   localparam int unsigned DOT_W   = 19;  // |dot| <= 131072
   localparam int unsigned FADE_W  = 17;  // 0..65536
   localparam int unsigned NOISE_W = 18;

   typedef logic [7:0]          cell_type;
   typedef logic [FRAC_W-1:0]   frac_type;
   typedef logic signed [DOT_W-1:0] dot_type;
   typedef logic [FADE_W-1:0]   fade_type;

   localparam logic [7:0] PERM_ROM [256] = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
      8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
      8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
      8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
      8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
      8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
      8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
      8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
      8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
      8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
      8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
      8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
      8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
      8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
      8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
      8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
      8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
      8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
      8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
      8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
      8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
      8'd215,8'd61,8'd156,8'd180
   };

   // Dot product of gradient h with offset (dx,dy,dz).
   function automatic dot_type grad_dot(input logic [3:0] h, input dot_type dx,
                                        input dot_type dy, input dot_type dz);
      dot_type r;
      begin
         case (h)
            4'd0, 4'd12: r = dx + dy;
            4'd1, 4'd13: r = dy - dx;
            4'd2:        r = dx - dy;
            4'd3:        r = -dx - dy;
            4'd4:        r = dx + dz;
            4'd5:        r = dz - dx;
            4'd6:        r = dx - dz;
            4'd7:        r = -dx - dz;
            4'd8:        r = dy + dz;
            4'd9, 4'd14: r = dz - dy;
            4'd10:       r = dy - dz;
            4'd11, 4'd15: r = -dy - dz;
            default:     r = '0;
         endcase
         grad_dot = r;
      end
   endfunction

endpackage
`default_nettype wire

### hw/rtl/gn3d_fade.sv
`default_nettype none
// Smoothstep 3t^2-2t^3 over three pipeline stages; advances when en is high.
module gn3d_fade (
   input  wire                     clock,
   input  wire                     en,
   input  wire gn3d_pkg::frac_type t_in,
   output gn3d_pkg::fade_type      s_out
);
   import gn3d_pkg::*;

   logic [31:0] t2_ff;
   frac_type    t_ff;
   logic [47:0] t3_ff;
   logic [49:0] t2s_ff;
   fade_type    s_ff;
   logic [49:0] v_in;

   assign v_in = t2s_ff - {1'b0, t3_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (en) begin
         t2_ff  <= t_in * t_in;
         t_ff   <= t_in;
         t3_ff  <= t2_ff * t_ff;
         t2s_ff <= {t2_ff, 16'd0} + {1'b0, t2_ff, 17'd0};
         s_ff   <= FADE_W'((v_in + 50'h80000000) >> 32);
      end
   end

   assign s_out = s_ff;
endmodule
`default_nettype wire

### hw/rtl/gn3d_lerp.sv
`default_nettype none
// Registered lerp: (a*(65536-s)+b*s) rounded half up to Q.16.
module gn3d_lerp (
   input  wire                     clock,
   input  wire                     en,
   input  wire gn3d_pkg::dot_type  a,
   input  wire gn3d_pkg::dot_type  b,
   input  wire gn3d_pkg::fade_type s,
   output gn3d_pkg::dot_type       r
);
   import gn3d_pkg::*;

   logic signed [37:0] pa_ff, pb_ff;
   logic signed [38:0] sum_in;
   dot_type            r_ff;

   assign sum_in = 39'(pa_ff) + 39'(pb_ff) + 39'sd32768;

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff <= 38'(a) * $signed({1'b0, FADE_W'(18'd65536 - 18'(s))});
         pb_ff <= 38'(b) * $signed({1'b0, s});
         r_ff  <= DOT_W'(sum_in >>> 16);
      end
   end

   assign r = r_ff;
endmodule
`default_nettype wire

### hw/rtl/gradient_noise_3d.sv
`default_nettype none
// Channel   | Ports                               | Direction
// request   | req_valid/ready, req_coord_x/y/z    | in
// response  | rsp_valid/ready, rsp_noise_value    | out
//
// One request per cycle while the output is not stalled, through a fixed pipeline.
// Hash stages read the 256-entry permutation ROM twice, four times and eight times in the x, y and z stages.
// Whole pipeline advances when the output register is empty or taken.
// Stall holds every stage; nothing is dropped or repeated.
// Reset clears only the stage valid bits.
module gradient_noise_3d #(
   parameter int unsigned NORM_SHIFT = 4
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [31:0] req_coord_x,
   input  wire  [31:0] req_coord_y,
   input  wire  [31:0] req_coord_z,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic signed [17:0] rsp_noise_value
);
   import gn3d_pkg::*;

   localparam int unsigned FB = 8 + NORM_SHIFT;
   localparam int unsigned NST = 12;

   logic [NST-1:0] vld_ff;
   logic           en;

   // advance whenever the last stage is free or being taken
   assign en        = !vld_ff[NST-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   // stage 1: split coordinates
   cell_type cx_ff, cy_ff, cz_ff;
   frac_type fx_ff, fy_ff, fz_ff;

   function automatic frac_type frac_of(input logic [31:0] c);
      logic [47:0] w;
      begin
         w = {c, 16'd0} >> FB;
         frac_of = w[15:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff <= 8'(req_coord_x >> FB);
         cy_ff <= 8'(req_coord_y >> FB);
         cz_ff <= 8'(req_coord_z >> FB);
         fx_ff <= frac_of(req_coord_x);
         fy_ff <= frac_of(req_coord_y);
         fz_ff <= frac_of(req_coord_z);
      end
   end

   // stage 2..4: hash chain, fractions delayed alongside
   logic [7:0] hx_ff [2];
   logic [7:0] hy_ff [4];
   logic [3:0] hz_ff [8];
   cell_type   cy2_ff, cz2_ff, cz3_ff;
   frac_type   fxd_ff [3], fyd_ff [3], fzd_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 2; i++) hx_ff[i] <= PERM_ROM[8'(cx_ff + 8'(i))];
         cy2_ff <= cy_ff;
         cz2_ff <= cz_ff;
         for (int i = 0; i < 4; i++)
            hy_ff[i] <= PERM_ROM[8'(cy2_ff + 8'(i % 2) + hx_ff[i/2])];
         cz3_ff <= cz2_ff;
         for (int i = 0; i < 8; i++)
            hz_ff[i] <= PERM_ROM[8'(cz3_ff + 8'(i % 2) + hy_ff[i/2])][3:0];
         fxd_ff[0] <= fx_ff; fyd_ff[0] <= fy_ff; fzd_ff[0] <= fz_ff;
         for (int i = 1; i < 3; i++) begin
            fxd_ff[i] <= fxd_ff[i-1]; fyd_ff[i] <= fyd_ff[i-1]; fzd_ff[i] <= fzd_ff[i-1];
         end
      end
   end

   // stage 5: dot products, corner index = {x,y,z}
   dot_type g_ff [8];
   dot_type ox [2], oy [2], oz [2];
   assign ox[0] = DOT_W'(fxd_ff[2]); assign ox[1] = DOT_W'(fxd_ff[2]) - 19'sd65536;
   assign oy[0] = DOT_W'(fyd_ff[2]); assign oy[1] = DOT_W'(fyd_ff[2]) - 19'sd65536;
   assign oz[0] = DOT_W'(fzd_ff[2]); assign oz[1] = DOT_W'(fzd_ff[2]) - 19'sd65536;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 8; i++)
            g_ff[i] <= grad_dot(hz_ff[i], ox[i/4], oy[(i/2)%2], oz[i%2]);
      end
   end

   // fades: start at stage 2, ready at stage 4; delay to match lerp use
   fade_type u_s, v_s, w_s;
   fade_type u_ff, v_ff [3], w_ff [5];
   gn3d_fade fade_x (.clock(clock), .en(en), .t_in(fx_ff), .s_out(u_s));
   gn3d_fade fade_y (.clock(clock), .en(en), .t_in(fy_ff), .s_out(v_s));
   gn3d_fade fade_z (.clock(clock), .en(en), .t_in(fz_ff), .s_out(w_s));

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff <= u_s;
         v_ff[0] <= v_s; w_ff[0] <= w_s;
         for (int i = 1; i < 3; i++) v_ff[i] <= v_ff[i-1];
         for (int i = 1; i < 5; i++) w_ff[i] <= w_ff[i-1];
      end
   end

   // x blends: stages 6-7
   dot_type xr [4];
   for (genvar k = 0; k < 4; k++) begin : g_xl
      gn3d_lerp lx (.clock(clock), .en(en), .a(g_ff[k]), .b(g_ff[k+4]),
                    .s(u_ff), .r(xr[k]));
   end
   // y blends: stages 8-9 (xr index = y*2+z, yr index = z)
   dot_type yr [2];
   for (genvar k = 0; k < 2; k++) begin : g_yl
      gn3d_lerp ly (.clock(clock), .en(en), .a(xr[k]), .b(xr[k+2]),
                    .s(v_ff[2]), .r(yr[k]));
   end
   // z blend: stages 10-11
   dot_type zr;
   gn3d_lerp lz (.clock(clock), .en(en), .a(yr[0]), .b(yr[1]),
                 .s(w_ff[4]), .r(zr));

   // stage 12: saturate
   logic signed [17:0] out_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         if (zr > 19'sd131071)       out_ff <= 18'sd131071;
         else if (zr < -19'sd131072) out_ff <= -18'sd131072;
         else                        out_ff <= 18'(zr);
      end
   end
   assign rsp_noise_value = out_ff;
endmodule
`default_nettype wire

### hw/rtl/gn3d_checker.sv
`default_nettype none
`include "gradient_noise_3d_macros.svh"
module gn3d_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [17:0] rsp_noise_value
);
   `GN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `GN_ASSERT_NEXT(a_val_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_noise_value))
   `GN_ASSERT_IMP(a_ready_free, clock, reset, !rsp_valid, req_ready)
   `GN_ASSERT_IMP(a_stall, clock, reset, rsp_valid && !rsp_ready, !req_ready)
endmodule

bind gradient_noise_3d gn3d_checker u_chk (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_noise_value(rsp_noise_value)
);
`default_nettype wire
